>>> hw/rtl/sgi_pkg.sv
// Shared constants for the segment intersection block.
// Used by sgi_lane and segment_intersection; depends on nothing else.

package sgi_pkg;

	localparam int TOL_W = 8;
	localparam logic [TOL_W-1:0] TOL_RESET = 8'd3;

	localparam logic OP_SEG  = 1'b0;
	localparam logic OP_RECT = 1'b1;

	localparam int N_EDGES = 4;

endpackage

>>> hw/rtl/sgi_lane.sv
// One pipelined line-crossing test: Cramer determinants, long division, box check.
// Depends on sgi_pkg; instantiated by segment_intersection.

module sgi_lane
	import sgi_pkg::*;
#(
	parameter int COORD_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [TOL_W-1:0]               tolerance,
	input  logic signed [COORD_WIDTH-1:0]  ax1,
	input  logic signed [COORD_WIDTH-1:0]  ay1,
	input  logic signed [COORD_WIDTH-1:0]  ax2,
	input  logic signed [COORD_WIDTH-1:0]  ay2,
	input  logic signed [COORD_WIDTH-1:0]  bx1,
	input  logic signed [COORD_WIDTH-1:0]  by1,
	input  logic signed [COORD_WIDTH-1:0]  bx2,
	input  logic signed [COORD_WIDTH-1:0]  by2,
	output logic                           hit,
	output logic signed [COORD_WIDTH-1:0]  point_x,
	output logic signed [COORD_WIDTH-1:0]  point_y
);

	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 1;
	localparam int PW   = 2 * W;
	localparam int D1W  = 2 * W + 1;
	localparam int MW   = 2 * W + 2;
	localparam int DENW = 2 * W + 3;
	localparam int PPW  = 2 * W + 2;
	localparam int TW   = 3 * W + 2;
	localparam int NW   = 3 * W + 3;
	localparam int QB   = W + 1;
	localparam int QW   = QB + 1;
	localparam int CMPW = 3 * W + 4;
	localparam int BW   = 8 * DW;
	localparam int SW   = BW + 5;

	localparam int SD_NEGY = 0;
	localparam int SD_NEGX = 1;
	localparam int SD_OVFY = 2;
	localparam int SD_OVFX = 3;
	localparam int SD_DZ   = 4;

	localparam logic signed [QW-1:0] QMAX = QW'((64'd1 << (W - 1)) - 64'd1);
	localparam logic signed [QW-1:0] QMIN = ~QMAX;

	// stage 1
	logic signed [PW-1:0]  p1_s1, p2_s1, p3_s1, p4_s1;
	logic signed [DW-1:0]  dxa_s1, dya_s1, dxb_s1, dyb_s1;
	logic signed [W-1:0]   axlo_s1, axhi_s1, aylo_s1, ayhi_s1;
	logic signed [W-1:0]   bxlo_s1, bxhi_s1, bylo_s1, byhi_s1;
	// stage 2
	logic signed [D1W-1:0] d1_s2, d2_s2;
	logic signed [MW-1:0]  m1_s2, m2_s2;
	logic signed [DW-1:0]  dxa_s2, dya_s2, dxb_s2, dyb_s2;
	logic [BW-1:0]         bnd_s2;
	// stage 3
	logic signed [DENW-1:0] den_s3;
	logic signed [PPW-1:0]  hxb_s3, lxb_s3, hxa_s3, lxa_s3;
	logic signed [PPW-1:0]  hyb_s3, lyb_s3, hya_s3, lya_s3;
	logic [BW-1:0]          bnd_s3;
	// stage 4
	logic signed [DENW-1:0] den_s4;
	logic signed [TW-1:0]   tx1_s4, tx2_s4, ty1_s4, ty2_s4;
	logic [BW-1:0]          bnd_s4;
	// stage 5
	logic signed [NW-1:0]   nx_s5, ny_s5;
	logic [DENW-1:0]        absd_s5;
	logic                   negd_s5, dz_s5;
	logic [BW-1:0]          bnd_s5;
	// stage 6
	logic [NW-1:0]          absnx_s6, absny_s6;
	logic [DENW-1:0]        absd_s6;
	logic                   negx_s6, negy_s6, dz_s6;
	logic [BW-1:0]          bnd_s6;
	// stage 7
	logic [CMPW-1:0]        rx_s7, ry_s7;
	logic [DENW-1:0]        ad_s7;
	logic [SW-1:0]          sd_s7;
	// divider stages
	logic [CMPW-1:0]        rx_sd [1:QB];
	logic [CMPW-1:0]        ry_sd [1:QB];
	logic [QB-1:0]          qx_sd [1:QB];
	logic [QB-1:0]          qy_sd [1:QB];
	logic [DENW-1:0]        ad_sd [1:QB];
	logic [SW-1:0]          sd_sd [1:QB];
	// sign stage
	logic signed [QW-1:0]   qx_sg, qy_sg;
	logic [SW-1:0]          sd_sg;
	// final stage
	logic                   hit_sf;
	logic signed [W-1:0]    px_sf, py_sf;

	logic signed [DW-1:0]   tol_ext;
	logic signed [W:0]      d1h, d2h, d1l, d2l;

	assign tol_ext = $signed(DW'(tolerance));
	assign d1h = d1_s2[D1W-1:W];
	assign d2h = d2_s2[D1W-1:W];
	assign d1l = $signed({1'b0, d1_s2[W-1:0]});
	assign d2l = $signed({1'b0, d2_s2[W-1:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1   <= ax1 * ay2;
			p2_s1   <= ax2 * ay1;
			p3_s1   <= bx1 * by2;
			p4_s1   <= bx2 * by1;
			dxa_s1  <= DW'(ax1) - DW'(ax2);
			dya_s1  <= DW'(ay1) - DW'(ay2);
			dxb_s1  <= DW'(bx1) - DW'(bx2);
			dyb_s1  <= DW'(by1) - DW'(by2);
			axlo_s1 <= (ax1 < ax2) ? ax1 : ax2;
			axhi_s1 <= (ax1 < ax2) ? ax2 : ax1;
			aylo_s1 <= (ay1 < ay2) ? ay1 : ay2;
			ayhi_s1 <= (ay1 < ay2) ? ay2 : ay1;
			bxlo_s1 <= (bx1 < bx2) ? bx1 : bx2;
			bxhi_s1 <= (bx1 < bx2) ? bx2 : bx1;
			bylo_s1 <= (by1 < by2) ? by1 : by2;
			byhi_s1 <= (by1 < by2) ? by2 : by1;

			d1_s2  <= D1W'(p1_s1) - D1W'(p2_s1);
			d2_s2  <= D1W'(p3_s1) - D1W'(p4_s1);
			m1_s2  <= dxa_s1 * dyb_s1;
			m2_s2  <= dxb_s1 * dya_s1;
			dxa_s2 <= dxa_s1;
			dya_s2 <= dya_s1;
			dxb_s2 <= dxb_s1;
			dyb_s2 <= dyb_s1;
			// widen each box by the tolerance on every side
			bnd_s2 <= {DW'(byhi_s1) + tol_ext, DW'(bylo_s1) - tol_ext,
				DW'(bxhi_s1) + tol_ext, DW'(bxlo_s1) - tol_ext,
				DW'(ayhi_s1) + tol_ext, DW'(aylo_s1) - tol_ext,
				DW'(axhi_s1) + tol_ext, DW'(axlo_s1) - tol_ext};

			// split d1, d2 into a signed high and an unsigned low half
			den_s3 <= DENW'(m1_s2) - DENW'(m2_s2);
			hxb_s3 <= d1h * dxb_s2;
			lxb_s3 <= d1l * dxb_s2;
			hxa_s3 <= d2h * dxa_s2;
			lxa_s3 <= d2l * dxa_s2;
			hyb_s3 <= d1h * dyb_s2;
			lyb_s3 <= d1l * dyb_s2;
			hya_s3 <= d2h * dya_s2;
			lya_s3 <= d2l * dya_s2;
			bnd_s3 <= bnd_s2;

			den_s4 <= den_s3;
			tx1_s4 <= (TW'(hxb_s3) <<< W) + TW'(lxb_s3);
			tx2_s4 <= (TW'(hxa_s3) <<< W) + TW'(lxa_s3);
			ty1_s4 <= (TW'(hyb_s3) <<< W) + TW'(lyb_s3);
			ty2_s4 <= (TW'(hya_s3) <<< W) + TW'(lya_s3);
			bnd_s4 <= bnd_s3;

			nx_s5   <= NW'(tx1_s4) - NW'(tx2_s4);
			ny_s5   <= NW'(ty1_s4) - NW'(ty2_s4);
			absd_s5 <= den_s4[DENW-1] ? DENW'(-den_s4) : DENW'(den_s4);
			negd_s5 <= den_s4[DENW-1];
			dz_s5   <= (den_s4 == '0);
			bnd_s5  <= bnd_s4;

			absnx_s6 <= nx_s5[NW-1] ? NW'(-nx_s5) : NW'(nx_s5);
			absny_s6 <= ny_s5[NW-1] ? NW'(-ny_s5) : NW'(ny_s5);
			negx_s6  <= nx_s5[NW-1] ^ negd_s5;
			negy_s6  <= ny_s5[NW-1] ^ negd_s5;
			absd_s6  <= absd_s5;
			dz_s6    <= dz_s5;
			bnd_s6   <= bnd_s5;

			// a quotient too wide for the divider lies outside every box
			rx_s7 <= CMPW'(absnx_s6);
			ry_s7 <= CMPW'(absny_s6);
			ad_s7 <= absd_s6;
			sd_s7 <= {bnd_s6, dz_s6,
				CMPW'(absnx_s6) >= (CMPW'(absd_s6) << QB),
				CMPW'(absny_s6) >= (CMPW'(absd_s6) << QB),
				negx_s6, negy_s6};
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= QB; j++) begin : g_div
		localparam int SH = QB - j;
		localparam logic [QB-1:0] QBIT = QB'(1) << SH;
		logic [CMPW-1:0] rx_in, ry_in, shd;
		logic [QB-1:0]   qx_in, qy_in;
		logic [DENW-1:0] ad_in;
		logic [SW-1:0]   sd_in;
		logic            gex, gey;

		if (j == 1) begin : g_first
			assign rx_in = rx_s7;
			assign ry_in = ry_s7;
			assign qx_in = '0;
			assign qy_in = '0;
			assign ad_in = ad_s7;
			assign sd_in = sd_s7;
		end else begin : g_next
			assign rx_in = rx_sd[j-1];
			assign ry_in = ry_sd[j-1];
			assign qx_in = qx_sd[j-1];
			assign qy_in = qy_sd[j-1];
			assign ad_in = ad_sd[j-1];
			assign sd_in = sd_sd[j-1];
		end

		assign shd = CMPW'(ad_in) << SH;
		assign gex = (rx_in >= shd);
		assign gey = (ry_in >= shd);

		always_ff @(posedge clk) begin
			if (en) begin
				rx_sd[j] <= gex ? rx_in - shd : rx_in;
				ry_sd[j] <= gey ? ry_in - shd : ry_in;
				qx_sd[j] <= gex ? (qx_in | QBIT) : qx_in;
				qy_sd[j] <= gey ? (qy_in | QBIT) : qy_in;
				ad_sd[j] <= ad_in;
				sd_sd[j] <= sd_in;
			end
		end
	end

	logic signed [QW-1:0] mx, my;
	assign mx = $signed({1'b0, qx_sd[QB]});
	assign my = $signed({1'b0, qy_sd[QB]});

	always_ff @(posedge clk) begin
		if (en) begin
			qx_sg <= sd_sd[QB][SD_NEGX] ? -mx : mx;
			qy_sg <= sd_sd[QB][SD_NEGY] ? -my : my;
			sd_sg <= sd_sd[QB];
		end
	end

	logic signed [DW-1:0] bv [0:7];
	logic                 in_box, hit_c;
	logic signed [W-1:0]  sx, sy;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			bv[k] = $signed(sd_sg[5 + k*DW +: DW]);
		end
		in_box = (qx_sg >= QW'(bv[0])) && (qx_sg <= QW'(bv[1]))
			&& (qy_sg >= QW'(bv[2])) && (qy_sg <= QW'(bv[3]))
			&& (qx_sg >= QW'(bv[4])) && (qx_sg <= QW'(bv[5]))
			&& (qy_sg >= QW'(bv[6])) && (qy_sg <= QW'(bv[7]));
		hit_c = in_box && !sd_sg[SD_DZ] && !sd_sg[SD_OVFX] && !sd_sg[SD_OVFY];
		sx = (qx_sg > QMAX) ? W'(QMAX) : (qx_sg < QMIN) ? W'(QMIN) : W'(qx_sg);
		sy = (qy_sg > QMAX) ? W'(QMAX) : (qy_sg < QMIN) ? W'(QMIN) : W'(qy_sg);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_sf <= hit_c;
			px_sf  <= hit_c ? sx : '0;
			py_sf  <= hit_c ? sy : '0;
		end
	end

	assign hit     = hit_sf;
	assign point_x = px_sf;
	assign point_y = py_sf;

endmodule

>>> hw/rtl/segment_intersection.sv
// The request passes through COORD_WIDTH + 10 lane stages, of which COORD_WIDTH + 1 are
// long-division steps, then the output register that drives m_tvalid. Throughput: one
// request per cycle while the skid entry is empty, four lanes in parallel.
// An output register plus one skid entry let input flow while a result waits.
// Reset clears all valid bits and sets tolerance to 3; datapath registers are not reset.
// Depends on sgi_pkg and sgi_lane.

module segment_intersection
	import sgi_pkg::*;
#(
	parameter int COORD_WIDTH = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [TOL_W-1:0]                  cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  logic [8*COORD_WIDTH-1:0]          s_tdata,
	// opcode
	input  logic [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// point_x, point_y, zero padding
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	// hit
	output logic [0:0]                        m_tuser
);

	localparam int W     = COORD_WIDTH;
	localparam int NSL   = W + 10;
	localparam int OUT_W = ((2*W+7)/8)*8;

	logic [TOL_W-1:0] tol_q;
	logic [NSL-1:0]   v_q, op_q;
	logic             en;

	logic                 out_v_q, skid_v_q;
	logic                 out_hit_q, skid_hit_q;
	logic signed [W-1:0]  out_px_q, out_py_q, skid_px_q, skid_py_q;

	logic signed [W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
	logic signed [W-1:0] e_x1 [N_EDGES], e_y1 [N_EDGES], e_x2 [N_EDGES], e_y2 [N_EDGES];
	logic                l_hit [N_EDGES];
	logic signed [W-1:0] l_px [N_EDGES], l_py [N_EDGES];

	logic                c_hit;
	logic signed [W-1:0] c_px, c_py;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// pipeline advances unless the skid entry is occupied
	assign en       = !skid_v_q;
	assign s_tready = en;

	assign ax1 = $signed(s_tdata[0*W +: W]);
	assign ay1 = $signed(s_tdata[1*W +: W]);
	assign ax2 = $signed(s_tdata[2*W +: W]);
	assign ay2 = $signed(s_tdata[3*W +: W]);
	assign bx1 = $signed(s_tdata[4*W +: W]);
	assign by1 = $signed(s_tdata[5*W +: W]);
	assign bx2 = $signed(s_tdata[6*W +: W]);
	assign by2 = $signed(s_tdata[7*W +: W]);

	// lane 0 carries segment A or the top edge; lanes 1-3 left, bottom, right
	always_comb begin
		e_x1[0] = ax1;  e_y1[0] = ay1;
		e_x2[0] = ax2;  e_y2[0] = (s_tuser[0] == OP_RECT) ? ay1 : ay2;
		e_x1[1] = ax1;  e_y1[1] = ay1;  e_x2[1] = ax1;  e_y2[1] = ay2;
		e_x1[2] = ax1;  e_y1[2] = ay2;  e_x2[2] = ax2;  e_y2[2] = ay2;
		e_x1[3] = ax2;  e_y1[3] = ay1;  e_x2[3] = ax2;  e_y2[3] = ay2;
	end

	for (genvar g = 0; g < N_EDGES; g++) begin : g_lane
		sgi_lane #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_lane (
			.clk       (clk),
			.en        (en),
			.tolerance (tol_q),
			.ax1       (e_x1[g]),
			.ay1       (e_y1[g]),
			.ax2       (e_x2[g]),
			.ay2       (e_y2[g]),
			.bx1       (bx1),
			.by1       (by1),
			.bx2       (bx2),
			.by2       (by2),
			.hit       (l_hit[g]),
			.point_x   (l_px[g]),
			.point_y   (l_py[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NSL-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_q <= {op_q[NSL-2:0], s_tuser[0]};
		end
	end

	always_comb begin
		if (op_q[NSL-1] == OP_RECT) begin
			c_hit = l_hit[0] || l_hit[1] || l_hit[2] || l_hit[3];
			c_px  = '0;
			c_py  = '0;
		end else begin
			c_hit = l_hit[0];
			c_px  = l_px[0];
			c_py  = l_py[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= en && v_q[NSL-1];
			end
		end else if (en && v_q[NSL-1]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_hit_q <= skid_hit_q;
				out_px_q  <= skid_px_q;
				out_py_q  <= skid_py_q;
			end else begin
				out_hit_q <= c_hit;
				out_px_q  <= c_px;
				out_py_q  <= c_py;
			end
		end else if (en && v_q[NSL-1]) begin
			skid_hit_q <= c_hit;
			skid_px_q  <= c_px;
			skid_py_q  <= c_py;
		end
	end

	assign m_tvalid   = out_v_q;
	assign m_tdata    = OUT_W'({out_py_q, out_px_q});
	assign m_tuser[0] = out_hit_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while output register empty");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_tready && en && v_q[NSL-1]) |=> skid_v_q)
		else $error("finished result dropped during output stall");

	a_empty_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |=> !skid_v_q)
		else $error("skid filled while output register was free");

endmodule
